### rtl/bcpe_pkg.sv
// Shared types and constants for the Bezier curve point evaluator.
package bcpe_pkg;

   localparam int COORD_W = 32;   // signed Q15.16 coordinate
   localparam int DEG_W   = 3;    // degree register width
   localparam int SLOT_W  = 3;    // control point slot field width
   localparam int PARAM_W = 17;   // curve parameter field width

   localparam logic       ACT_LOAD  = 1'b0;
   localparam logic       ACT_EVAL  = 1'b1;
   localparam logic [DEG_W-1:0] DEG_RESET = 3'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             load;   // write a control point slot
      logic             copy;   // seed working row from store, latch u
      logic             step;   // one interpolation on row[0], row[1]
      logic             last;   // final step of the current level
      logic [DEG_W-1:0] tail;   // outputs in the current level
   } cmd_type;

endpackage

### rtl/bcpe_lerp.sv
// One-coordinate fixed-point interpolation a + floor((b - a) * u / ONE).
module bcpe_lerp
   import bcpe_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic signed [COORD_W-1:0]   a,
   input  logic signed [COORD_W-1:0]   b,
   input  logic        [FRAC_BITS:0]   u,
   output logic signed [COORD_W-1:0]   res
);

   localparam int PROD_W = COORD_W + 1 + FRAC_BITS + 2;

   logic signed [COORD_W:0]   diff;
   logic signed [PROD_W-1:0]  prod;

   // a*(ONE-u) + b*u == a*ONE + (b-a)*u, so floor of the sum over ONE
   // is a plus the floored scaled difference. Result stays in range.
   assign diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
   assign prod = diff * $signed({1'b0, u});
   assign res  = a + prod[FRAC_BITS +: COORD_W];

endmodule

### rtl/bcpe_dpath.sv
// Datapath: control point store, working row and shared 3-axis lerp unit.
module bcpe_dpath
   import bcpe_pkg::*;
#(
   parameter int MAX_POINTS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic [SLOT_W-1:0]         req_point_index,
   input  logic signed [COORD_W-1:0] req_load_x,
   input  logic signed [COORD_W-1:0] req_load_y,
   input  logic signed [COORD_W-1:0] req_load_z,
   input  logic [PARAM_W-1:0]        req_param_u,
   output point_type                 result
);

   localparam int U_W   = FRAC_BITS + 1;
   localparam int CMP_W = (U_W > PARAM_W) ? U_W : PARAM_W;
   localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;

   point_type             store_ff [MAX_POINTS];
   logic [MAX_POINTS-1:0] valid_ff;
   point_type             row_ff   [MAX_POINTS];
   logic [U_W-1:0]        u_ff;

   logic [CMP_W-1:0]      u_ext;
   logic [CMP_W-1:0]      u_sat;
   point_type             lerp_res;

   // parameter above one clamps to one
   assign u_ext = CMP_W'(req_param_u);
   assign u_sat = (u_ext > ONE_C) ? ONE_C : u_ext;

   bcpe_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x (
      .a(row_ff[0].x), .b(row_ff[1].x), .u(u_ff), .res(lerp_res.x)
   );
   bcpe_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y (
      .a(row_ff[0].y), .b(row_ff[1].y), .u(u_ff), .res(lerp_res.y)
   );
   bcpe_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
      .a(row_ff[0].z), .b(row_ff[1].z), .u(u_ff), .res(lerp_res.z)
   );

   // store: out-of-range slots match no entry and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.load) begin
         for (int j = 0; j < MAX_POINTS; j++) begin
            if (int'(req_point_index) == j) begin
               valid_ff[j] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int j = 0; j < MAX_POINTS; j++) begin
            if (int'(req_point_index) == j) begin
               store_ff[j] <= '{x: req_load_x, y: req_load_y, z: req_load_z};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy) begin
         u_ff <= U_W'(u_sat);
      end
   end

   // working row: each step shifts left by one and appends at tail;
   // the last step of a level drops the spent entry with a shift of two
   always_ff @(posedge clock) begin
      if (cmd.copy) begin
         for (int j = 0; j < MAX_POINTS; j++) begin
            row_ff[j] <= valid_ff[j] ? store_ff[j] : '0;
         end
      end else if (cmd.step) begin
         for (int j = 0; j < MAX_POINTS; j++) begin
            if (cmd.last) begin
               if (int'(cmd.tail) - 1 == j) begin
                  row_ff[j] <= lerp_res;
               end else if (j + 2 < MAX_POINTS) begin
                  row_ff[j] <= row_ff[j + 2];
               end
            end else begin
               if (int'(cmd.tail) == j) begin
                  row_ff[j] <= lerp_res;
               end else if (j + 1 < MAX_POINTS) begin
                  row_ff[j] <= row_ff[j + 1];
               end
            end
         end
      end
   end

   assign result = row_ff[0];

endmodule

### rtl/bcpe_ctrl.sv
// Controller: degree register, level/step sequencer and beat handshake.
module bcpe_ctrl
   import bcpe_pkg::*;
#(
   parameter int MAX_POINTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_action,
   input  logic             csr_write_en,
   input  logic [DEG_W-1:0] csr_write_data,
   output logic             busy,
   output logic             rsp_valid,
   output cmd_type          cmd
);

   state_type        state_ff, state_in;
   logic [DEG_W-1:0] degree_ff;
   logic [DEG_W-1:0] lvl_ff, lvl_in;
   logic [DEG_W-1:0] stp_ff, stp_in;
   logic [DEG_W-1:0] deg_n;
   logic             last_step;

   // degree limited by the store depth
   assign deg_n = (int'(degree_ff) > MAX_POINTS - 1) ? DEG_W'(MAX_POINTS - 1) : degree_ff;
   assign last_step = (stp_ff == lvl_ff - DEG_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         degree_ff <= DEG_RESET;
         lvl_ff    <= '0;
         stp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         stp_ff   <= stp_in;
         if (csr_write_en) begin
            degree_ff <= csr_write_data;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      stp_in    = stp_ff;
      cmd       = '0;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff) inside
         ST_IDLE, ST_DONE: begin
            rsp_valid = (state_ff == ST_DONE);
            state_in  = ST_IDLE;
            if (start) begin
               if (req_action == ACT_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.copy = 1'b1;
                  if (deg_n == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_RUN;
                     lvl_in   = deg_n;
                     stp_in   = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
            cmd.last = last_step;
            cmd.tail = lvl_ff;
            if (last_step) begin
               stp_in = '0;
               if (lvl_ff == DEG_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  lvl_in = lvl_ff - DEG_W'(1);
               end
            end else begin
               stp_in = stp_ff + DEG_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/bezier_curve_point_eval.sv
// Top level: de Casteljau Bezier curve point evaluator, 3-D, fixed point.
//
//  channel  | ports                                   | beat taken when
//  ---------+-----------------------------------------+-----------------------
//  request  | start, busy, req_action, req_point_index,| start & !busy
//           | req_load_x/y/z, req_param_u             |
//  response | rsp_valid, rsp_point_x/y/z              | rsp_valid (one cycle)
//  csr      | csr_write_en, csr_write_data (degree)   | csr_write_en
//
// A load beat writes its slot on the accepting edge.
// An evaluate beat seeds the working row from the store, then runs
// degree*(degree+1)/2 steps on the single shared 3-axis lerp unit, one step
// per cycle (28 at degree 7); the result strobes in the cycle after, where
// the next request beat is already taken. Reset clears the store (zeros),
// sets degree to 3 and idles the sequencer. The receiver cannot stall.
module bezier_curve_point_eval
   import bcpe_pkg::*;
#(
   parameter int MAX_POINTS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [SLOT_W-1:0]         req_point_index,
   input  logic signed [COORD_W-1:0] req_load_x,
   input  logic signed [COORD_W-1:0] req_load_y,
   input  logic signed [COORD_W-1:0] req_load_z,
   input  logic [PARAM_W-1:0]        req_param_u,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [COORD_W-1:0] rsp_point_z,
   input  logic                      csr_write_en,
   input  logic [DEG_W-1:0]          csr_write_data
);

   cmd_type   cmd;
   point_type result;

   bcpe_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_action     (req_action),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .cmd            (cmd)
   );

   bcpe_dpath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_point_index (req_point_index),
      .req_load_x      (req_load_x),
      .req_load_y      (req_load_y),
      .req_load_z      (req_load_z),
      .req_param_u     (req_param_u),
      .result          (result)
   );

   // row head holds steady through the strobe cycle
   assign rsp_point_x = result.x;
   assign rsp_point_y = result.y;
   assign rsp_point_z = result.z;

endmodule

### tb/bezier_curve_point_eval_test.sv
// Self-checking testbench for bezier_curve_point_eval: directed table, then random degree phases.
module bezier_curve_point_eval_test;
   import bcpe_pkg::*;

   localparam int                 NUM_SLOTS     = 8;
   localparam int                 FRAC          = 16;
   localparam logic [PARAM_W-1:0] U_ONE         = 17'h10000;  // 1.0 in Q1.16
   localparam logic [PARAM_W-1:0] U_TOP         = 17'h1FFFF;  // largest field value
   localparam int                 PHASE_BEATS   = 137;        // 9 phases, ~1230 beats
   localparam int                 SETTLE_CYCLES = 4;          // load beats finish at their accepting edge
   localparam int                 TAIL_CYCLES   = 40;         // > one degree-7 evaluation
   localparam int                 LIMIT_TIME    = 2_000_000;  // hang guard limit; clock period is 4

   // directed control points, packed as {x, y, z}
   localparam point_type CP0 = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
   localparam point_type CP1 = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};
   localparam point_type CP2 = {32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000};
   localparam point_type CP3 = {32'hF543_2110, 32'h5555_5555, 32'hAAAA_AAAA};
   localparam point_type CP4 = {32'h0001_8000, 32'hFFFE_8000, 32'h4000_0000};
   localparam point_type CP7 = {32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};

   // one line of the stimulus table: a degree write or a request beat
   typedef struct {
      logic               is_cfg;
      logic [DEG_W-1:0]   cfg_degree;
      logic               action;
      logic [SLOT_W-1:0]  slot;
      point_type          pt;
      logic [PARAM_W-1:0] u;
      logic               has_known;   // expected point typed into the table
      point_type          known;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_action;
   logic [SLOT_W-1:0]         req_point_index;
   logic signed [COORD_W-1:0] req_load_x;
   logic signed [COORD_W-1:0] req_load_y;
   logic signed [COORD_W-1:0] req_load_z;
   logic [PARAM_W-1:0]        req_param_u;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_point_x;
   logic signed [COORD_W-1:0] rsp_point_y;
   logic signed [COORD_W-1:0] rsp_point_z;
   logic                      csr_write_en;
   logic [DEG_W-1:0]          csr_write_data;

   // travels alongside the request beat so the checker sees it at the same edge
   logic      row_has_known;
   point_type row_known;

   // shadow copy of the block's state
   point_type        ctrl_pts [NUM_SLOTS];
   logic [DEG_W-1:0] deg_model;
   point_type        pending_points [$];   // curve points still owed by the block
   int               fault_count;
   logic             gaps_on;

   bezier_curve_point_eval u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_point_index (req_point_index),
      .req_load_x      (req_load_x),
      .req_load_y      (req_load_y),
      .req_load_z      (req_load_z),
      .req_param_u     (req_param_u),
      .rsp_valid       (rsp_valid),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: de Casteljau in Q15.16, floor shift after each lerp.
   // Longint holds a*(1-u) + b*u without overflow (|sum| < 2^48).
   // ------------------------------------------------------------------
   function automatic longint lerp_q16(input longint a, input longint b,
                                       input longint u, input longint u1);
      return (a * u1 + b * u) >>> FRAC;
   endfunction

   function automatic point_type casteljau_point(input logic [PARAM_W-1:0] u_raw);
      longint    rx [NUM_SLOTS];
      longint    ry [NUM_SLOTS];
      longint    rz [NUM_SLOTS];
      longint    u;
      longint    u1;
      point_type p;
      // parameter above one saturates to one
      u  = (u_raw > U_ONE) ? longint'(U_ONE) : longint'(u_raw);
      u1 = longint'(U_ONE) - u;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         rx[i] = ctrl_pts[i].x;
         ry[i] = ctrl_pts[i].y;
         rz[i] = ctrl_pts[i].z;
      end
      // degree zero skips the loop: the result is control point 0
      for (int k = 1; k <= int'(deg_model); k++) begin
         for (int i = 0; i + k <= int'(deg_model); i++) begin
            rx[i] = lerp_q16(rx[i], rx[i+1], u, u1);
            ry[i] = lerp_q16(ry[i], ry[i+1], u, u1);
            rz[i] = lerp_q16(rz[i], rz[i+1], u, u1);
         end
      end
      p.x = rx[0][31:0];
      p.y = ry[0][31:0];
      p.z = rz[0][31:0];
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Checker: results compared first, then the edge's config/request beats
   // update the shadow state. All sampling is of pre-edge values.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
         deg_model = DEG_RESET;
      end else begin
         if (rsp_valid) begin
            if (pending_points.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected point x=%h y=%h z=%h", $realtime,
                           rsp_point_x, rsp_point_y, rsp_point_z);
            end else begin
               want = pending_points.pop_front();
               if (rsp_point_x !== want.x || rsp_point_y !== want.y ||
                   rsp_point_z !== want.z) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: point mismatch exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                              $realtime, want.x, want.y, want.z,
                              rsp_point_x, rsp_point_y, rsp_point_z);
               end
            end
         end
         if (csr_write_en)
            deg_model = csr_write_data;
         if (start && !busy) begin
            if (req_action == ACT_LOAD)
               ctrl_pts[req_point_index] = {req_load_x, req_load_y, req_load_z};
            else
               pending_points.insert(pending_points.size(),
                                     row_has_known ? row_known
                                                   : casteljau_point(req_param_u));
         end
      end
   end

   // ------------------------------------------------------------------
   // Table row builders
   // ------------------------------------------------------------------
   function automatic stim_row_type load_row(input logic [SLOT_W-1:0] slot,
                                             input point_type pt);
      stim_row_type r;
      r        = '{default: '0};
      r.action = ACT_LOAD;
      r.slot   = slot;
      r.pt     = pt;
      return r;
   endfunction

   function automatic stim_row_type eval_row(input logic [PARAM_W-1:0] u);
      stim_row_type r;
      r        = '{default: '0};
      r.action = ACT_EVAL;
      r.u      = u;
      return r;
   endfunction

   function automatic stim_row_type known_eval_row(input logic [PARAM_W-1:0] u,
                                                   input point_type p);
      stim_row_type r;
      r           = eval_row(u);
      r.has_known = 1'b1;
      r.known     = p;
      return r;
   endfunction

   function automatic stim_row_type degree_row(input logic [DEG_W-1:0] d);
      stim_row_type r;
      r            = '{default: '0};
      r.is_cfg     = 1'b1;
      r.cfg_degree = d;
      return r;
   endfunction

   // corners often, otherwise anything
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return 32'($urandom_range(32'h3FFFF)) - 32'h20000;  // near +-2.0
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [PARAM_W-1:0] random_param();
      case ($urandom_range(7))
         0:       return '0;
         1:       return U_ONE;
         2:       return PARAM_W'($urandom_range(U_TOP, U_ONE + 1));  // saturates
         3:       return PARAM_W'($urandom_range(15, 1));
         4:       return U_ONE - PARAM_W'($urandom_range(15, 1));
         default: return PARAM_W'($urandom_range(U_ONE, 0));
      endcase
   endfunction

   function automatic stim_row_type random_load_row(input logic [SLOT_W-1:0] slot);
      return load_row(slot, {random_coord(), random_coord(), random_coord()});
   endfunction

   // ------------------------------------------------------------------
   // Driver tasks
   // ------------------------------------------------------------------
   // present one beat, hold it until start & !busy at an edge, then maybe idle
   task automatic drive_beat(input stim_row_type r);
      start           <= 1'b1;
      req_action      <= r.action;
      req_point_index <= r.slot;
      req_load_x      <= r.pt.x;
      req_load_y      <= r.pt.y;
      req_load_z      <= r.pt.z;
      req_param_u     <= r.u;
      row_has_known   <= r.has_known;
      row_known       <= r.known;
      @(posedge clock);
      while (busy) @(posedge clock);
      // short gaps mostly, long ones to land inside and past an evaluation
      if (gaps_on && $urandom_range(99) < 35) begin
         start <= 1'b0;
         repeat (($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1))
            @(posedge clock);
      end
   endtask

   // sender holds off until every owed point is back and the block is quiet
   task automatic drain(input int extra);
      start <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0 || busy) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_degree(input logic [DEG_W-1:0] d);
      drain(SETTLE_CYCLES);
      csr_write_en   <= 1'b1;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      stim_row_type     rows [$];
      logic [DEG_W-1:0] deg_plan [9];

      reset           = 1'b1;
      start           = 1'b0;
      req_action      = ACT_LOAD;
      req_point_index = '0;
      req_load_x      = '0;
      req_load_y      = '0;
      req_load_z      = '0;
      req_param_u     = '0;
      csr_write_en    = 1'b0;
      csr_write_data  = '0;
      row_has_known   = 1'b0;
      row_known       = '0;
      fault_count     = 0;
      gaps_on         = 1'b1;
      deg_plan        = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd5, 3'd7, 3'd4, 3'd6, 3'd3};

      // directed: reset state, corner coordinates, u at 0, 1.0 and above,
      // degree zero and the top degree
      rows.insert(rows.size(), known_eval_row('0, '0));   // store is zero after reset
      rows.insert(rows.size(), known_eval_row(U_TOP, '0));
      rows.insert(rows.size(), load_row(3'd0, CP0));
      rows.insert(rows.size(), load_row(3'd1, CP1));
      rows.insert(rows.size(), load_row(3'd2, CP2));
      rows.insert(rows.size(), load_row(3'd3, CP3));
      rows.insert(rows.size(), load_row(3'd7, CP7));
      rows.insert(rows.size(), load_row(3'd4, CP4));
      rows.insert(rows.size(), known_eval_row('0, CP0));  // u = 0 gives the first point
      rows.insert(rows.size(), known_eval_row(U_ONE, CP3));  // u = 1 gives the last point
      rows.insert(rows.size(), known_eval_row(U_ONE + 1, CP3));  // saturates to 1.0
      rows.insert(rows.size(), known_eval_row(U_TOP, CP3));
      rows.insert(rows.size(), eval_row(17'h08000));
      rows.insert(rows.size(), eval_row(17'h00001));
      rows.insert(rows.size(), eval_row(17'h0FFFF));
      rows.insert(rows.size(), degree_row(3'd0));
      rows.insert(rows.size(), known_eval_row(17'h08000, CP0));  // degree zero: point 0
      rows.insert(rows.size(), known_eval_row(U_TOP, CP0));
      rows.insert(rows.size(), degree_row(3'd7));
      rows.insert(rows.size(), known_eval_row('0, CP0));
      rows.insert(rows.size(), known_eval_row(U_ONE, CP7));
      rows.insert(rows.size(), eval_row(17'h04321));
      rows.insert(rows.size(), eval_row(17'h0C000));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_cfg)
            write_degree(rows[i].cfg_degree);
         else
            drive_beat(rows[i]);
      end

      // random phases: fill the whole store, then a load/evaluate mix
      for (int ph = 0; ph < 9; ph++) begin
         write_degree(deg_plan[ph]);
         gaps_on = (ph != 5);   // one phase runs back to back
         for (int s = 0; s < NUM_SLOTS; s++)
            drive_beat(random_load_row(SLOT_W'(s)));
         for (int n = NUM_SLOTS; n < PHASE_BEATS; n++) begin
            if ($urandom_range(99) < 40)
               drive_beat(random_load_row(SLOT_W'($urandom_range(NUM_SLOTS - 1))));
            else
               drive_beat(eval_row(random_param()));
         end
      end

      drain(TAIL_CYCLES);
      if (pending_points.size() != 0) begin
         fault_count++;
         $display("%0d curve points never arrived", pending_points.size());
      end
      if (fault_count == 0)
         $display("bezier_curve_point_eval_test: done, clean");
      else
         $display("bezier_curve_point_eval_test: done, errors");
      $finish;
   end

   // hang guard
   initial begin
      #(LIMIT_TIME);
      $display("bezier_curve_point_eval_test: done, errors");
      $finish;
   end

endmodule
